// File: design/midi_cmp_pkg.sv
// Shared types and constants for the MIDI channel message parser.
package midi_cmp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned CHAN_W  = 4;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_RECEIVE_CHANNEL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OMNI_ENABLE     = 1'd1;

    localparam logic [3:0] STATUS_NOTE_OFF = 4'h8;
    localparam logic [3:0] STATUS_NOTE_ON  = 4'h9;
    localparam logic [3:0] STATUS_CC       = 4'hB;
    localparam logic [3:0] STATUS_PC       = 4'hC;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_OFF_NUM = 3'd1,
        ST_ON_NUM  = 3'd2,
        ST_CC_NUM  = 3'd3,
        ST_PC      = 3'd4,
        ST_OFF_VAL = 3'd5,
        ST_ON_VAL  = 3'd6,
        ST_CC_VAL  = 3'd7
    } parse_state_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NOTE_OFF = 2'd0,
        KIND_NOTE_ON  = 2'd1,
        KIND_CC       = 2'd2,
        KIND_PC       = 2'd3
    } event_kind_t;

endpackage

// File: design/midi_channel_message_parser.sv
// Top level of the MIDI channel message parser.
// Each accepted request carries one received MIDI byte; it is registered, then
// parsed, and a note off, note on, control change or program change request
// leaves through the output register when a message completes.
// One byte is taken every cycle while the output side keeps up; an accepted
// byte passes through the input register and then the result register on its
// way to the result. In idle a byte is a status byte, accepted when omni
// mode is on or its channel matches; the following one or two bytes are data,
// taken whole. Configuration writes take effect at once and are meant for idle.
module midi_channel_message_parser
    import midi_cmp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     rx_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [KIND_W-1:0]     event_kind,
    output logic [BYTE_W-1:0]     first_value,
    output logic [BYTE_W-1:0]     second_value
);

    logic [CHAN_W-1:0] receive_channel_reg;
    logic              omni_enable_reg;

    logic              in1_valid_reg;
    logic [BYTE_W-1:0] in1_byte_reg;

    parse_state_t      state_reg;
    parse_state_t      state_next;
    logic [BYTE_W-1:0] held_reg;
    logic [BYTE_W-1:0] held_next;

    logic              out_valid_reg;
    event_kind_t       kind_reg;
    event_kind_t       kind_next;
    logic [BYTE_W-1:0] first_reg;
    logic [BYTE_W-1:0] first_next;
    logic [BYTE_W-1:0] second_reg;
    logic [BYTE_W-1:0] second_next;
    logic              fire;

    logic              advance;
    logic              in_accept;
    logic              chan_ok;

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = in1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;
    assign chan_ok   = omni_enable_reg || (in1_byte_reg[CHAN_W-1:0] == receive_channel_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            receive_channel_reg <= '0;
            omni_enable_reg     <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_RECEIVE_CHANNEL: receive_channel_reg <= wr_data[CHAN_W-1:0];
                CFG_OMNI_ENABLE:     omni_enable_reg     <= wr_data[0];
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in1_byte_reg <= rx_byte;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        held_next   = held_reg;
        fire        = 1'b0;
        kind_next   = KIND_PC;
        first_next  = in1_byte_reg;
        second_next = in1_byte_reg;
        case (state_reg)
            ST_IDLE:
            begin
                state_next = ST_IDLE;
                if (chan_ok)
                begin
                    case (in1_byte_reg[BYTE_W-1:CHAN_W])
                        STATUS_NOTE_OFF: state_next = ST_OFF_NUM;
                        STATUS_NOTE_ON:  state_next = ST_ON_NUM;
                        STATUS_CC:       state_next = ST_CC_NUM;
                        STATUS_PC:       state_next = ST_PC;
                        default:         state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OFF_NUM:
            begin
                held_next  = in1_byte_reg;
                state_next = ST_OFF_VAL;
            end
            ST_ON_NUM:
            begin
                held_next  = in1_byte_reg;
                state_next = ST_ON_VAL;
            end
            ST_CC_NUM:
            begin
                held_next  = in1_byte_reg;
                state_next = ST_CC_VAL;
            end
            ST_PC:
            begin
                state_next  = ST_IDLE;
                fire        = 1'b1;
                kind_next   = KIND_PC;
                second_next = '0;
            end
            ST_OFF_VAL:
            begin
                state_next = ST_IDLE;
                fire       = 1'b1;
                kind_next  = KIND_NOTE_OFF;
                first_next = held_reg;
            end
            ST_ON_VAL:
            begin
                state_next = ST_IDLE;
                fire       = 1'b1;
                kind_next  = KIND_NOTE_ON;
                first_next = held_reg;
            end
            ST_CC_VAL:
            begin
                state_next = ST_IDLE;
                fire       = 1'b1;
                kind_next  = KIND_CC;
                first_next = held_reg;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in1_valid_reg && fire;
            if (in1_valid_reg)
            begin
                state_reg <= state_next;
                held_reg  <= held_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in1_valid_reg && fire)
        begin
            kind_reg   <= kind_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign event_kind   = kind_reg;
    assign first_value  = first_reg;
    assign second_value = second_reg;

`ifndef SYNTH
    a_stall_only_on_blocked_output: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall))
        else $error("input stalled while the output register could advance");

    a_result_from_registered_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in1_valid_reg))
        else $error("result appeared without a registered byte");

    a_pc_entered_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PC && $past(state_reg) != ST_PC) |-> ($past(state_reg) == ST_IDLE))
        else $error("program change state entered from a data state");

    a_pc_second_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && kind_reg == KIND_PC) |-> (second_reg == '0))
        else $error("program change result carries a nonzero second value");
`endif

endmodule
